// ===== src/epd_pkg.sv =====
// Package for the escaped packet deframer.
// Holds byte codes, command limits, result kinds and the default buffer depth.
// Depends on nothing; every other source file imports it.
package epd_pkg;

  localparam int unsigned DEFAULT_BUFFER_DEPTH = 256;

  localparam logic [7:0] ESC_BYTE        = 8'd27;
  localparam logic [7:0] END_BYTE        = 8'd0;
  localparam logic [7:0] CMD_FIRST_EVENT = 8'd2;
  localparam logic [7:0] CMD_COUNT       = 8'd6;  // eComNumCommands

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_BAD   = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic {
    OP_READ = 1'b0,
    OP_END  = 1'b1
  } op_e;

  typedef struct packed {
    logic clearing;  // reset clearing pass still running
    logic is_end;    // current input byte is an unescaped end marker
  } rx_status_t;

endpackage

// ===== src/escaped_packet_deframer.sv =====
// Escaped packet deframer: receive side of escape-byte stuffing. Each input
// transaction is either a received byte (func_i = 0) or a buffer read
// (func_i = 1). Data bytes go into a ring buffer of BufferDepth slots; an
// unescaped ESC (27) is dropped and makes the next byte literal; an unescaped
// NUL closes the packet, skips one slot, and takes the byte at the packet's
// start slot as the command: commands 2 to 5 give an event result, 0 and 1
// give nothing, 6 and above give a bad-command result. A read returns the
// byte at read_addr_i modulo BufferDepth. One transaction is accepted per
// cycle while in_ready_o is high. A read or end-of-packet result goes
// through the buffer RAM's registered read, which captures the byte at the
// accepting edge, and then the output register. A stalled result holds the
// read stage, which then holds off the input. After reset the buffer is
// cleared one slot per cycle, so in_ready_o stays low until every slot has
// been cleared.
// Uses epd_pkg, epd_ram and epd_rx_ctrl.
module escaped_packet_deframer
  import epd_pkg::*;
#(
  parameter int unsigned BufferDepth = DEFAULT_BUFFER_DEPTH,
  localparam int unsigned AW         = $clog2(BufferDepth)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] read_addr_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [1:0] event_code_o,
  output logic [7:0] packet_start_o,
  output logic [7:0] read_data_o
);

  rx_status_t    status;
  logic [AW-1:0] start_slot;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] addr_mod;
  logic [7:0]    rd_data;

  logic          accept;
  logic          needs_read;

  // read stage: holds the transaction whose buffer byte is being fetched
  logic          s1_valid_q, s1_valid_d;
  op_e           s1_op_q;
  logic [AW-1:0] s1_start_q;
  logic          s1_adv;

  // result built from the read stage
  logic          res_has;
  kind_e         res_kind;
  logic [1:0]    res_code;
  logic [7:0]    res_start;
  logic [7:0]    res_data;

  // output register
  logic          out_valid_q, out_valid_d;
  kind_e         out_kind_q;
  logic [1:0]    out_code_q;
  logic [7:0]    out_start_q;
  logic [7:0]    out_data_q;

  // Reduce the read address to a slot. Narrow buffers use an elaboration-time table.
  if (BufferDepth < 256) begin : g_addr_mod
    logic [AW-1:0] mod_tbl [256];
    for (genvar g = 0; g < 256; g++) begin : g_tbl
      assign mod_tbl[g] = AW'(g % BufferDepth);
    end
    assign addr_mod = mod_tbl[read_addr_i];
  end else begin : g_addr_wide
    assign addr_mod = AW'(read_addr_i);
  end

  epd_rx_ctrl #(
    .BufferDepth(BufferDepth)
  ) u_rx_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .rx_byte_i   (rx_byte_i),
    .status_o    (status),
    .start_slot_o(start_slot),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  epd_ram #(
    .Width(8),
    .Depth(BufferDepth)
  ) u_buffer (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Advance the read stage whenever the output register is free or being drained;
  // accept a new transaction whenever the clearing pass is done and the read stage will have room.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !status.clearing && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;
  assign needs_read = func_i || status.is_end;

  // Issue the buffer read at acceptance; the RAM holds its data while stalled.
  assign rd_en   = accept && needs_read;
  assign rd_addr = func_i ? addr_mod : start_slot;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rd_en) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_op_q    <= func_i ? OP_READ : OP_END;
      s1_start_q <= start_slot;
    end
  end

  // Decode the fetched byte: read data, or the packet's command byte.
  always_comb begin
    res_has   = 1'b1;
    res_kind  = KIND_READ;
    res_code  = 2'd0;
    res_start = 8'd0;
    res_data  = 8'd0;
    unique case (s1_op_q)
      OP_READ: begin
        res_data = rd_data;
      end
      OP_END: begin
        priority if (rd_data >= CMD_COUNT) begin
          res_kind  = KIND_BAD;
          res_start = 8'(s1_start_q);
        end else if (rd_data >= CMD_FIRST_EVENT) begin
          res_kind  = KIND_EVENT;
          res_code  = 2'(rd_data - CMD_FIRST_EVENT);
          res_start = 8'(s1_start_q);
        end else begin
          // silent commands: drop the transaction
          res_has = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && res_has) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_has) begin
      out_kind_q  <= res_kind;
      out_code_q  <= res_code;
      out_start_q <= res_start;
      out_data_q  <= res_data;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign event_code_o   = out_code_q;
  assign packet_start_o = out_start_q;
  assign read_data_o    = out_data_q;

endmodule

// ===== src/epd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Width and depth are parameters; uses epd_pkg for the default depth only.
module epd_ram
  import epd_pkg::*;
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = DEFAULT_BUFFER_DEPTH,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/epd_rx_ctrl.sv =====
// Receive control: escape tracking, write and start slot pointers, reset clearing pass.
// Drives the buffer write port; uses epd_pkg for byte codes and the status struct.
module epd_rx_ctrl
  import epd_pkg::*;
#(
  parameter int unsigned BufferDepth = DEFAULT_BUFFER_DEPTH,
  localparam int unsigned AW         = $clog2(BufferDepth)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          func_i,
  input  logic [7:0]    rx_byte_i,
  output rx_status_t    status_o,
  output logic [AW-1:0] start_slot_o,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o
);

  localparam logic [AW-1:0] LastSlot = AW'(BufferDepth - 1);

  logic [AW-1:0] write_slot_q, write_slot_d;
  logic [AW-1:0] start_slot_q, start_slot_d;
  logic          esc_q, esc_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clearing_q, clearing_d;
  logic [AW-1:0] write_slot_nxt;
  logic          is_esc, is_end, is_data;

  assign is_esc  = !func_i && !esc_q && (rx_byte_i == ESC_BYTE);
  assign is_end  = !func_i && !esc_q && (rx_byte_i == END_BYTE);
  assign is_data = !func_i && !is_esc && !is_end;

  assign write_slot_nxt = (write_slot_q == LastSlot) ? '0 : write_slot_q + AW'(1);

  always_comb begin
    write_slot_d = write_slot_q;
    start_slot_d = start_slot_q;
    esc_d        = esc_q;
    if (accept_i) begin
      priority if (is_esc) begin
        esc_d = 1'b1;
      end else if (is_end) begin
        // skip one slot and open the next packet there
        write_slot_d = write_slot_nxt;
        start_slot_d = write_slot_nxt;
      end else if (is_data) begin
        write_slot_d = write_slot_nxt;
        esc_d        = 1'b0;
      end
    end
  end

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == LastSlot) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      start_slot_q <= '0;
      esc_q        <= 1'b0;
      clr_cnt_q    <= '0;
      clearing_q   <= 1'b1;
    end else begin
      write_slot_q <= write_slot_d;
      start_slot_q <= start_slot_d;
      esc_q        <= esc_d;
      clr_cnt_q    <= clr_cnt_d;
      clearing_q   <= clearing_d;
    end
  end

  assign wr_en_o   = clearing_q || (accept_i && is_data);
  assign wr_addr_o = clearing_q ? clr_cnt_q : write_slot_q;
  assign wr_data_o = clearing_q ? 8'd0 : rx_byte_i;

  assign status_o.clearing = clearing_q;
  assign status_o.is_end   = is_end;
  assign start_slot_o      = start_slot_q;

endmodule

// ===== src/epd_checker.sv =====
// Port-level checker for the escaped packet deframer, bound to the top level.
// Uses epd_pkg for result kinds; sees only the top-level ports.
module epd_checker
  import epd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       func_i,
  input logic [7:0] rx_byte_i,
  input logic [7:0] read_addr_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [1:0] event_code_o,
  input logic [7:0] packet_start_o,
  input logic [7:0] read_data_o
);

  // a waiting input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(func_i) &&
      $stable(rx_byte_i) && $stable(read_addr_i))
    else $error("input changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
      $stable(event_code_o) && $stable(packet_start_o) && $stable(read_data_o))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_EVENT) || (kind_o == KIND_BAD) || (kind_o == KIND_READ))
    else $error("illegal result kind");

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_READ) |-> (event_code_o == 2'd0) && (packet_start_o == 8'd0))
    else $error("read result carries packet fields");

  a_packet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_READ) |-> (read_data_o == 8'd0) &&
      ((kind_o == KIND_EVENT) || (event_code_o == 2'd0)))
    else $error("packet result carries stray fields");

endmodule

bind escaped_packet_deframer epd_checker u_epd_checker (.*);
